### src/chip8_instruction_executor_top_assert.svh
// Assertion helpers for the instruction executor.
// Both use the enclosing module's clk and rst_n.
`ifndef CHIP8_INSTRUCTION_EXECUTOR_TOP_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_TOP_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define CHIP8IE_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Trigger at one edge implies the outcome at the next.
`define CHIP8IE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### src/chip8ie_pkg.sv
`default_nettype none
package chip8ie_pkg;

  localparam int MEMORY_SIZE       = 4096;
  localparam int STACK_DEPTH_DEF   = 16;
  localparam int CNT_W             = 5;
  localparam int PC_W              = 12;
  localparam logic [PC_W-1:0] PC_RESET = 12'h200;

  // register index of the flag register
  localparam logic [3:0] F_IDX = 4'hF;

  localparam logic [15:0] INSTR_CLS = 16'h00E0;
  localparam logic [15:0] INSTR_RET = 16'h00EE;

  // instruction groups (top nibble)
  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SEI  = 4'h3;
  localparam logic [3:0] GRP_SNEI = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LDI  = 4'h6;
  localparam logic [3:0] GRP_ADDI = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;

  // 8xyN ALU operations
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_INVALID     = 3'd1,
    ERR_STACK_EMPTY = 3'd2,
    ERR_ADDR_BOUNDS = 3'd3,
    ERR_STACK_FULL  = 3'd4
  } err_t;

  // register file write request
  typedef struct packed {
    logic       vx_we;
    logic [3:0] x;
    logic [7:0] vx_wd;
    logic       vf_we;
    logic [7:0] vf_wd;
  } regwr_t;

  // outcome of executing one instruction
  typedef struct packed {
    logic [PC_W-1:0] pc;
    logic            push;
    logic            pop;
    err_t            err;
    logic            cls;
    regwr_t          wr;
    logic [7:0]      vx_value;
    logic [7:0]      vf_value;
  } exec_res_t;

endpackage
`default_nettype wire

### src/chip8ie_regfile.sv
`default_nettype none
// V0..VE in a 15-entry array with registered reads, VF in its own register.
module chip8ie_regfile (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               rd_en,
  input  wire logic [3:0]         rd_x,
  input  wire logic [3:0]         rd_y,
  input  wire chip8ie_pkg::regwr_t wr,
  output logic [7:0]              vx_o,
  output logic [7:0]              vy_o,
  output logic [7:0]              vf_o
);

  localparam int ARR_N = 15;

  logic [7:0]       mem [0:ARR_N-1];
  logic [ARR_N-1:0] vld_r;
  logic [7:0]       vf_r, vf_nxt;
  logic [7:0]       rdx_r, rdy_r;
  logic             x_f_r, y_f_r;
  logic             arr_we;

  assign arr_we = wr.vx_we && (wr.x != chip8ie_pkg::F_IDX);

  always_comb begin
    priority if (wr.vx_we && (wr.x == chip8ie_pkg::F_IDX)) begin
      vf_nxt = wr.vx_wd;
    end else if (wr.vf_we) begin
      vf_nxt = wr.vf_wd;
    end else begin
      vf_nxt = vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      vf_r  <= 8'h00;
    end else begin
      vf_r <= vf_nxt;
      if (arr_we) begin
        vld_r[wr.x] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (arr_we) begin
      mem[wr.x] <= wr.vx_wd;
    end
  end

  // read with bypass of a write landing on the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      x_f_r <= (rd_x == chip8ie_pkg::F_IDX);
      y_f_r <= (rd_y == chip8ie_pkg::F_IDX);
      priority if (arr_we && (wr.x == rd_x)) begin
        rdx_r <= wr.vx_wd;
      end else if ((rd_x == chip8ie_pkg::F_IDX) || !vld_r[rd_x]) begin
        rdx_r <= 8'h00;
      end else begin
        rdx_r <= mem[rd_x];
      end
      priority if (arr_we && (wr.x == rd_y)) begin
        rdy_r <= wr.vx_wd;
      end else if ((rd_y == chip8ie_pkg::F_IDX) || !vld_r[rd_y]) begin
        rdy_r <= 8'h00;
      end else begin
        rdy_r <= mem[rd_y];
      end
    end
  end

  assign vx_o = x_f_r ? vf_r : rdx_r;
  assign vy_o = y_f_r ? vf_r : rdy_r;
  assign vf_o = vf_r;

endmodule
`default_nettype wire

### src/chip8ie_exec.sv
`default_nettype none
// Decode and execute one instruction against the current state.
module chip8ie_exec #(
  parameter int STACK_DEPTH = chip8ie_pkg::STACK_DEPTH_DEF
) (
  input  wire logic [15:0]                        instr,
  input  wire logic [7:0]                         vx,
  input  wire logic [7:0]                         vy,
  input  wire logic [7:0]                         vf,
  input  wire logic [chip8ie_pkg::PC_W-1:0]       pc,
  input  wire logic [chip8ie_pkg::CNT_W-1:0]      cnt,
  input  wire logic [chip8ie_pkg::PC_W-1:0]       tos,
  output chip8ie_pkg::exec_res_t                  res
);

  localparam logic [12:0] MEM_LIM = 13'(chip8ie_pkg::MEMORY_SIZE);
  localparam logic [chip8ie_pkg::CNT_W-1:0] DEPTH = chip8ie_pkg::CNT_W'(STACK_DEPTH);

  logic [3:0]  grp, x, op;
  logic [7:0]  kk;
  logic [11:0] nnn;
  logic        addr_ok, skip_ok, skip_cond, skip_grp;
  logic [8:0]  sum;
  logic [7:0]  vf_fin;

  assign grp = instr[15:12];
  assign x   = instr[11:8];
  assign kk  = instr[7:0];
  assign nnn = instr[11:0];
  assign op  = instr[3:0];

  assign addr_ok = {1'b0, nnn} < MEM_LIM;
  assign skip_ok = ({1'b0, pc} + 13'd2) < MEM_LIM;
  assign sum     = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    res          = '0;
    res.pc       = pc;
    res.err      = chip8ie_pkg::ERR_NONE;
    res.wr.x     = x;
    skip_cond    = 1'b0;
    skip_grp     = 1'b0;
    unique case (grp)
      chip8ie_pkg::GRP_SYS: begin
        priority if (instr == chip8ie_pkg::INSTR_CLS) begin
          res.cls = 1'b1;
        end else if (instr == chip8ie_pkg::INSTR_RET) begin
          if (cnt == '0) begin
            res.err = chip8ie_pkg::ERR_STACK_EMPTY;
          end else begin
            res.pop = 1'b1;
            res.pc  = tos;
          end
        end else begin
          res.err = chip8ie_pkg::ERR_INVALID;
        end
      end
      chip8ie_pkg::GRP_JP: begin
        if (!addr_ok) begin
          res.err = chip8ie_pkg::ERR_ADDR_BOUNDS;
        end else begin
          res.pc = nnn;
        end
      end
      chip8ie_pkg::GRP_CALL: begin
        priority if (!addr_ok) begin
          res.err = chip8ie_pkg::ERR_ADDR_BOUNDS;
        end else if (cnt >= DEPTH) begin
          res.err = chip8ie_pkg::ERR_STACK_FULL;
        end else begin
          res.push = 1'b1;
          res.pc   = nnn;
        end
      end
      chip8ie_pkg::GRP_SEI: begin
        skip_grp  = 1'b1;
        skip_cond = (vx == kk);
      end
      chip8ie_pkg::GRP_SNEI: begin
        skip_grp  = 1'b1;
        skip_cond = (vx != kk);
      end
      chip8ie_pkg::GRP_SER: begin
        if (op != 4'h0) begin
          res.err = chip8ie_pkg::ERR_INVALID;
        end else begin
          skip_grp  = 1'b1;
          skip_cond = (vx == vy);
        end
      end
      chip8ie_pkg::GRP_LDI: begin
        res.wr.vx_we = 1'b1;
        res.wr.vx_wd = kk;
      end
      chip8ie_pkg::GRP_ADDI: begin
        res.wr.vx_we = 1'b1;
        res.wr.vx_wd = vx + kk;
      end
      chip8ie_pkg::GRP_ALU: begin
        res.wr.vx_we = 1'b1;
        unique case (op)
          chip8ie_pkg::ALU_MOV: res.wr.vx_wd = vy;
          chip8ie_pkg::ALU_OR:  res.wr.vx_wd = vx | vy;
          chip8ie_pkg::ALU_AND: res.wr.vx_wd = vx & vy;
          chip8ie_pkg::ALU_XOR: res.wr.vx_wd = vx ^ vy;
          chip8ie_pkg::ALU_ADD: begin
            res.wr.vx_wd = sum[7:0];
            res.wr.vf_we = 1'b1;
            res.wr.vf_wd = {7'd0, sum[8]};
          end
          chip8ie_pkg::ALU_SUB: begin
            res.wr.vx_wd = vx - vy;
            res.wr.vf_we = 1'b1;
            res.wr.vf_wd = {7'd0, (vx > vy)};
          end
          chip8ie_pkg::ALU_SHR: begin
            res.wr.vx_wd = {1'b0, vx[7:1]};
            res.wr.vf_we = 1'b1;
            res.wr.vf_wd = {7'd0, vx[0]};
          end
          chip8ie_pkg::ALU_SBN: begin
            res.wr.vx_wd = vy - vx;
            res.wr.vf_we = 1'b1;
            res.wr.vf_wd = {7'd0, (vy > vx)};
          end
          chip8ie_pkg::ALU_SHL: begin
            res.wr.vx_wd = {vx[6:0], 1'b0};
            res.wr.vf_we = 1'b1;
            res.wr.vf_wd = {7'd0, vx[7]};
          end
          default: begin
            res.wr.vx_we = 1'b0;
            res.err      = chip8ie_pkg::ERR_INVALID;
          end
        endcase
      end
      default: res.err = chip8ie_pkg::ERR_INVALID;
    endcase

    if (skip_grp && skip_cond) begin
      if (skip_ok) begin
        res.pc = pc + 12'd2;
      end else begin
        res.err = chip8ie_pkg::ERR_ADDR_BOUNDS;
      end
    end

    // flag first, then Vx, so Vx wins when it is VF
    priority if (res.wr.vx_we && (x == chip8ie_pkg::F_IDX)) begin
      vf_fin = res.wr.vx_wd;
    end else if (res.wr.vf_we) begin
      vf_fin = res.wr.vf_wd;
    end else begin
      vf_fin = vf;
    end
    res.vf_value = vf_fin;
    priority if (x == chip8ie_pkg::F_IDX) begin
      res.vx_value = vf_fin;
    end else if (res.wr.vx_we) begin
      res.vx_value = res.wr.vx_wd;
    end else begin
      res.vx_value = vx;
    end
  end

endmodule
`default_nettype wire

### src/chip8_instruction_executor_top.sv
// Stage 1 registers the accepted word; execute then fills the result register.
// Throughput: one instruction per cycle when out_ready allows, set by the
//   single execute stage updating regfile, PC and stack on the same edge.
// Reset (rst_n low, synchronous): V0..VF cleared, PC = 0x200, stack empty,
//   both pipeline stages emptied. No clearing pass; ready the cycle after.
`default_nettype none
module chip8_instruction_executor_top #(
  parameter int STACK_DEPTH = chip8ie_pkg::STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_instr,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      out_pc_after,
  output logic [2:0]       out_error,
  output logic             out_clear_display,
  output logic [7:0]       out_vx_value,
  output logic [7:0]       out_vf_value
);

  localparam int CNT_W = chip8ie_pkg::CNT_W;
  localparam int PC_W  = chip8ie_pkg::PC_W;
  // stack pointer width; at least one bit so depth 1 still elaborates
  localparam int SP_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // ---------------------------------------------------------------
  // Pipeline control
  //   stage 1 : instruction word plus registered Vx/Vy reads
  //   execute : stage 1 -> output register, state updated on that edge
  // ---------------------------------------------------------------
  logic                    s1_vld_r, s1_vld_nxt;
  logic [15:0]             s1_instr_r;
  logic                    out_vld_r, out_vld_nxt;
  logic                    fire;
  logic                    in_acc;

  // architectural state
  logic [PC_W-1:0]         pc_r, pc_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        cnt_m1;
  logic [PC_W-1:0]         stk [0:STACK_DEPTH-1];
  logic [PC_W-1:0]         tos;

  logic [7:0]              vx, vy, vf;
  chip8ie_pkg::exec_res_t  res;
  chip8ie_pkg::regwr_t     wr;

  // result register
  logic [PC_W-1:0]         o_pc_r;
  chip8ie_pkg::err_t       o_err_r;
  logic                    o_cls_r;
  logic [7:0]              o_vx_r, o_vf_r;

  // execute when stage 1 holds a word and the output slot is free or draining
  assign fire     = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || fire;
  assign in_acc   = in_valid && in_ready;

  assign s1_vld_nxt  = in_acc ? 1'b1 : (fire ? 1'b0 : s1_vld_r);
  assign out_vld_nxt = fire ? 1'b1 : ((out_vld_r && out_ready) ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_instr_r <= in_instr;
    end
  end

  // ---------------------------------------------------------------
  // Register file: read on accept, written on execute (with bypass)
  // ---------------------------------------------------------------
  always_comb begin
    wr       = res.wr;
    wr.vx_we = res.wr.vx_we && fire;
    wr.vf_we = res.wr.vf_we && fire;
  end

  chip8ie_regfile u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (in_acc),
    .rd_x  (in_instr[11:8]),
    .rd_y  (in_instr[7:4]),
    .wr    (wr),
    .vx_o  (vx),
    .vy_o  (vy),
    .vf_o  (vf)
  );

  // ---------------------------------------------------------------
  // Return stack: top entry is read at count - 1
  // ---------------------------------------------------------------
  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign tos    = stk[cnt_m1[SP_W-1:0]];

  always_ff @(posedge clk) begin
    if (fire && res.push) begin
      stk[cnt_r[SP_W-1:0]] <= pc_r;
    end
  end

  // ---------------------------------------------------------------
  // Execute
  // ---------------------------------------------------------------
  chip8ie_exec #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_exec (
    .instr (s1_instr_r),
    .vx    (vx),
    .vy    (vy),
    .vf    (vf),
    .pc    (pc_r),
    .cnt   (cnt_r),
    .tos   (tos),
    .res   (res)
  );

  always_comb begin
    pc_nxt  = pc_r;
    cnt_nxt = cnt_r;
    if (fire) begin
      pc_nxt = res.pc;
      priority if (res.push) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else if (res.pop) begin
        cnt_nxt = cnt_m1;
      end else begin
        cnt_nxt = cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= chip8ie_pkg::PC_RESET;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (fire) begin
      o_pc_r  <= res.pc;
      o_err_r <= res.err;
      o_cls_r <= res.cls;
      o_vx_r  <= res.vx_value;
      o_vf_r  <= res.vf_value;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_pc_after      = o_pc_r;
  assign out_error         = o_err_r;
  assign out_clear_display = o_cls_r;
  assign out_vx_value      = o_vx_r;
  assign out_vf_value      = o_vf_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
`include "chip8_instruction_executor_top_assert.svh"

  `CHIP8IE_ASSERT_NOW(a_cnt_bound, cnt_r <= CNT_W'(STACK_DEPTH), "stack count over depth")
  `CHIP8IE_ASSERT_NOW(a_pc_matches, !out_vld_r || (pc_r == o_pc_r), "PC differs from result")
  `CHIP8IE_ASSERT_NOW(a_cls_clean, !(out_vld_r && o_cls_r) || (o_err_r == chip8ie_pkg::ERR_NONE),
                      "clear screen with error")
  `CHIP8IE_ASSERT_NEXT(a_push_cnt, fire && res.push, cnt_r == $past(cnt_r) + CNT_W'(1),
                       "push did not bump count")

endmodule
`default_nettype wire

### bench/tb_chip8_instruction_executor_top.sv
`timescale 1ns / 100ps

module tb_chip8_instruction_executor_top;
  import chip8ie_pkg::*;

  // One result word as the block presents it on the out_ channel.
  typedef struct packed {
    logic [11:0] pc_after;
    err_t        error;
    logic        clear_display;
    logic [7:0]  vx_value;
    logic [7:0]  vf_value;
  } exec_word_t;

  // Group F has no name in the package; every word in it is illegal.
  localparam logic [3:0] GRP_UNUSED = 4'hF;

  // Hold-off length for the back-pressure test, well past the pipeline depth.
  localparam int HOLD_CYCLES = 200;

  // Watchdog: 2 ms is ample for the slowest legal run.
  localparam int WATCHDOG_NS = 2_000_000;

  // ---------------------------------------------------------------------------
  // DUT connections. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [15:0] in_instr  = 16'h0000;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] out_pc_after;
  logic [2:0]  out_error;
  logic        out_clear_display;
  logic [7:0]  out_vx_value;
  logic [7:0]  out_vf_value;

  chip8_instruction_executor_top DUT (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_instr,
    .out_valid,
    .out_ready,
    .out_pc_after,
    .out_error,
    .out_clear_display,
    .out_vx_value,
    .out_vf_value
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow machine: V0..VF, PC and the return stack as the block should hold
  // them once every accepted word has executed.
  // ---------------------------------------------------------------------------
  logic [7:0]  v_regs     [16];
  logic [11:0] prog_pc;
  logic [11:0] call_stack [16];
  logic [4:0]  call_depth;

  // Results still owed by the block, oldest first.
  exec_word_t  owed_words[$];
  exec_word_t  oldest_word;

  int unsigned mismatches    = 0;
  int unsigned words_checked = 0;

  // Idle odds in percent, per cycle; changed between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Long receiver hold-off, timed in its own process.
  logic holding = 1'b0;
  event hold_start;

  function automatic void reset_machine();
    for (int i = 0; i < 16; i++) begin
      v_regs[i]     = 8'h00;
      call_stack[i] = 12'h000;
    end
    prog_pc    = PC_RESET;
    call_depth = 5'd0;
  endfunction

  // Conditional skip: only a taken skip can run off the end of memory.
  function automatic err_t skip_when(input logic cond);
    if (!cond) return ERR_NONE;
    if (int'(prog_pc) + 2 >= MEMORY_SIZE) return ERR_ADDR_BOUNDS;
    prog_pc = prog_pc + 12'd2;
    return ERR_NONE;
  endfunction

  // Executes one instruction on the shadow machine and returns the word the
  // block must produce for it.
  function automatic exec_word_t execute_instr(input logic [15:0] w);
    logic [3:0]  grp;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  op;
    logic [7:0]  kk;
    logic [11:0] nnn;
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [8:0]  sum;
    exec_word_t  r;
    grp = w[15:12];
    x   = w[11:8];
    y   = w[7:4];
    op  = w[3:0];
    kk  = w[7:0];
    nnn = w[11:0];
    vx  = v_regs[x];
    vy  = v_regs[y];
    r   = '0;
    r.error = ERR_NONE;
    case (grp)
      GRP_SYS: begin
        if (w == INSTR_CLS) begin
          r.clear_display = 1'b1;
        end else if (w == INSTR_RET) begin
          if (call_depth == 5'd0) begin
            r.error = ERR_STACK_EMPTY;
          end else begin
            call_depth = call_depth - 5'd1;
            prog_pc    = call_stack[call_depth[3:0]];
          end
        end else begin
          r.error = ERR_INVALID;
        end
      end
      GRP_JP: begin
        if (int'(nnn) >= MEMORY_SIZE) r.error = ERR_ADDR_BOUNDS;
        else prog_pc = nnn;
      end
      GRP_CALL: begin
        // address check takes precedence over the depth check
        if (int'(nnn) >= MEMORY_SIZE) begin
          r.error = ERR_ADDR_BOUNDS;
        end else if (call_depth >= STACK_DEPTH_DEF) begin
          r.error = ERR_STACK_FULL;
        end else begin
          call_stack[call_depth[3:0]] = prog_pc;
          call_depth = call_depth + 5'd1;
          prog_pc    = nnn;
        end
      end
      GRP_SEI:  r.error = skip_when(vx == kk);
      GRP_SNEI: r.error = skip_when(vx != kk);
      GRP_SER: begin
        if (op != 4'h0) r.error = ERR_INVALID;
        else r.error = skip_when(vx == vy);
      end
      GRP_LDI:  v_regs[x] = kk;
      GRP_ADDI: v_regs[x] = vx + kk;
      GRP_ALU: begin
        // VF first, then Vx: with x = F the result overwrites the flag
        case (op)
          ALU_MOV: v_regs[x] = vy;
          ALU_OR:  v_regs[x] = vx | vy;
          ALU_AND: v_regs[x] = vx & vy;
          ALU_XOR: v_regs[x] = vx ^ vy;
          ALU_ADD: begin
            sum           = {1'b0, vx} + {1'b0, vy};
            v_regs[F_IDX] = {7'd0, sum[8]};
            v_regs[x]     = sum[7:0];
          end
          ALU_SUB: begin
            v_regs[F_IDX] = (vx > vy) ? 8'd1 : 8'd0;
            v_regs[x]     = vx - vy;
          end
          ALU_SHR: begin
            v_regs[F_IDX] = {7'd0, vx[0]};
            v_regs[x]     = vx >> 1;
          end
          ALU_SBN: begin
            v_regs[F_IDX] = (vy > vx) ? 8'd1 : 8'd0;
            v_regs[x]     = vy - vx;
          end
          ALU_SHL: begin
            v_regs[F_IDX] = {7'd0, vx[7]};
            v_regs[x]     = {vx[6:0], 1'b0};
          end
          default: r.error = ERR_INVALID;
        endcase
      end
      default: r.error = ERR_INVALID;
    endcase
    r.pc_after = prog_pc;
    r.vx_value = v_regs[x];
    r.vf_value = v_regs[F_IDX];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. valid is only lowered during a random gap or a drain, and never
  // in the step where it is raised again.
  // ---------------------------------------------------------------------------
  task automatic send_instr(input logic [15:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_instr <= w;
    do @(posedge clk); while (!in_ready);
    // word taken at this edge: run it on the shadow machine straight away
    owed_words.push_back(execute_instr(w));
  endtask

  // Sender pauses until every owed result has been taken.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_words.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker. Outputs are sampled at the edge, before the DUT's
  // own updates land, so the compare is order-independent.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      if (owed_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d: result with nothing owed (pc %h err %0d)",
                   words_checked, out_pc_after, out_error);
      end else begin
        oldest_word = owed_words.pop_front();
        if (out_pc_after !== oldest_word.pc_after ||
            out_error !== oldest_word.error ||
            out_clear_display !== oldest_word.clear_display ||
            out_vx_value !== oldest_word.vx_value ||
            out_vf_value !== oldest_word.vf_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d exp/got: pc %h/%h err %0d/%0d cls %b/%b vx %h/%h vf %h/%h",
                     words_checked, oldest_word.pc_after, out_pc_after,
                     oldest_word.error, out_error,
                     oldest_word.clear_display, out_clear_display,
                     oldest_word.vx_value, out_vx_value,
                     oldest_word.vf_value, out_vf_value);
        end
      end
    end
    out_ready <= !holding && ($urandom_range(99) >= recv_idle_pct);
  end

  // Receiver hold-off, counted here so the sender can keep pushing meanwhile.
  initial begin
    forever begin
      @(hold_start);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_alu_op();
    case ($urandom_range(8))
      0:       return ALU_MOV;
      1:       return ALU_OR;
      2:       return ALU_AND;
      3:       return ALU_XOR;
      4:       return ALU_ADD;
      5:       return ALU_SUB;
      6:       return ALU_SHR;
      7:       return ALU_SBN;
      default: return ALU_SHL;
    endcase
  endfunction

  // Mostly legal instructions with random operands; skips compare against the
  // live register value half the time so that both outcomes are common.
  function automatic logic [15:0] next_instr();
    logic [3:0]  x;
    logic [3:0]  y;
    logic [7:0]  kk;
    logic [11:0] nnn;
    x  = 4'($urandom_range(15));
    y  = 4'($urandom_range(15));
    kk = $urandom_range(1) ? v_regs[x] : pick_byte();
    // some jumps land near the top of memory, where taken skips overflow
    nnn = ($urandom_range(2) == 0) ? 12'($urandom_range(12'hFFF, 12'hFF8))
                                   : 12'($urandom);
    case ($urandom_range(19))
      0:       return 16'($urandom);
      1:       return INSTR_CLS;
      2, 3:    return INSTR_RET;
      4, 5:    return {GRP_CALL, 12'($urandom)};
      6:       return {GRP_JP, nnn};
      7:       return {GRP_SEI, x, kk};
      8:       return {GRP_SNEI, x, kk};
      9:       return {GRP_SER, x, y,
                       ($urandom_range(3) == 0) ? 4'($urandom_range(15, 1)) : 4'h0};
      10, 11:  return {GRP_LDI, x, pick_byte()};
      12:      return {GRP_ADDI, x, pick_byte()};
      19:      return {GRP_ALU, x, y, 4'($urandom_range(15))};
      default: return {GRP_ALU, x, y, pick_alu_op()};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked words: every group and ALU op, illegal encodings, empty
  // return, flag as destination, carry/borrow edges and skips off the end.
  task automatic test_directed_cases();
    send_instr(INSTR_RET);                       // nothing on the stack
    send_instr(INSTR_CLS);
    send_instr({GRP_SYS, 12'hABC});              // other system words illegal
    send_instr({GRP_UNUSED, 12'h0FF});
    send_instr({GRP_LDI, 4'h1, 8'hFF});
    send_instr({GRP_LDI, 4'h2, 8'h01});
    send_instr({GRP_ALU, 4'h1, 4'h2, ALU_ADD});  // carry out, V1 wraps to 0
    send_instr({GRP_ALU, 4'h1, 4'h2, ALU_SUB});  // borrow, equal-ish edge
    send_instr({GRP_ALU, 4'h1, 4'h2, ALU_SBN});
    send_instr({GRP_LDI, F_IDX, 8'h80});
    send_instr({GRP_ALU, F_IDX, 4'h0, ALU_SHL}); // result beats the flag
    send_instr({GRP_ALU, 4'h1, 4'h0, ALU_SHR});
    send_instr({GRP_ALU, 4'h3, 4'h1, ALU_MOV});
    send_instr({GRP_ALU, 4'h3, 4'h2, ALU_OR});
    send_instr({GRP_ALU, 4'h3, 4'h1, ALU_AND});
    send_instr({GRP_ALU, 4'h3, 4'h2, ALU_XOR});
    send_instr({GRP_ALU, 4'h3, 4'h3, ALU_SUB});  // equal operands, flag clear
    send_instr({GRP_ALU, 4'h1, 4'h2, 4'h8});     // undefined ALU op
    send_instr({GRP_SER, 4'h1, 4'h2, 4'h1});     // non-zero low nibble
    send_instr({GRP_SER, 4'h3, 4'h3, 4'h0});
    send_instr({GRP_ADDI, 4'h4, 8'hFF});
    send_instr({GRP_SEI, 4'h1, v_regs[1]});
    send_instr({GRP_JP, 12'hFFE});
    send_instr({GRP_SEI, 4'h0, v_regs[0]});      // taken skip runs off the end
    send_instr({GRP_CALL, 12'hFFF});
    send_instr({GRP_SNEI, 4'h0, ~v_regs[0]});    // same at the last address
    send_instr(INSTR_RET);
  endtask

  // Fill the stack, overflow it once, then unwind past empty.
  task automatic test_stack_limits();
    for (int i = 0; i <= STACK_DEPTH_DEF; i++)
      send_instr({GRP_CALL, 12'($urandom)});
    for (int i = 0; i <= STACK_DEPTH_DEF; i++)
      send_instr(INSTR_RET);
  endtask

  task automatic test_random_programs(input int unsigned n_words);
    repeat (n_words) send_instr(next_instr());
  endtask

  // Receiver goes quiet while the sender keeps offering words, so the
  // pipeline fills and in_ready drops; then the sender drains it fully.
  task automatic test_backpressure();
    -> hold_start;
    repeat (40) send_instr(next_instr());
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_machine();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // busy sender, mostly stalled receiver
    send_idle_pct = 11;
    recv_idle_pct = 87;
    test_directed_cases();
    test_stack_limits();
    wait_for_results();
    test_random_programs(200);

    // mostly idle sender, eager receiver
    send_idle_pct = 87;
    recv_idle_pct = 11;
    test_random_programs(200);

    // flat out
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_programs(180);
    test_backpressure();

    // let anything stray surface once the pipeline has drained
    wait_for_results();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && owed_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule

### chip8_instruction_executor_top.f
+incdir+src
src/chip8ie_pkg.sv
src/chip8ie_regfile.sv
src/chip8ie_exec.sv
src/chip8_instruction_executor_top.sv
bench/tb_chip8_instruction_executor_top.sv
